// ----- hdl/gji_pkg.sv -----
package gji_pkg;

   localparam int MAX_N     = 8;
   localparam int FRAC_BITS = 16;
   localparam int CELLS     = MAX_N * MAX_N;
   localparam int CELL_W    = (CELLS > 1) ? $clog2(CELLS) : 1;
   localparam int CNT_W     = $clog2(CELLS + 1);
   localparam int N_W       = $clog2(MAX_N + 1);
   localparam int DIV_W     = 32 + FRAC_BITS;
   localparam logic signed [31:0] Q_ONE = 32'sd1 <<< FRAC_BITS;

   typedef struct packed {
      logic signed [31:0] element;
      logic               last_element;
   } gji_req_type;

   typedef struct packed {
      logic signed [31:0] entry;
      logic               last_entry;
      logic               singular;
   } gji_rsp_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_INIT, ST_COL, ST_SRCH,
      ST_SWA, ST_SWB, ST_SWC, ST_SWD,
      ST_PIV, ST_PIV2,
      ST_SCA, ST_SCB, ST_SCC, ST_SCD,
      ST_SHF, ST_SHG, ST_SHA, ST_SHB, ST_SHC, ST_SHD, ST_SHE, ST_SHW,
      ST_ORD, ST_OUT, ST_SING
   } gji_state_type;

   function automatic logic [N_W-1:0] order_n(input logic [3:0] size);
      logic [N_W-1:0] res;
      if (size == 4'd0) begin
         res = N_W'(1);
      end else if (32'(size) > MAX_N) begin
         res = N_W'(MAX_N);
      end else begin
         res = N_W'(size);
      end
      return res;
   endfunction

   function automatic logic [CELL_W-1:0] cell_addr(input logic [N_W-1:0] row,
                                                   input logic [N_W-1:0] col,
                                                   input logic [N_W-1:0] n);
      logic [2*N_W:0] t;
      t = (2*N_W+1)'(row) * (2*N_W+1)'(n) + (2*N_W+1)'(col);
      return t[CELL_W-1:0];
   endfunction

endpackage

// ----- hdl/gji_div.sv -----
module gji_div (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [31:0] x,
   input  logic signed [31:0] p,
   output logic               done,
   output logic signed [31:0] q
);
   import gji_pkg::*;

   localparam int CW = $clog2(DIV_W);

   logic             run_ff, run_in, fin_ff, fin_in, neg_ff, neg_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [DIV_W-1:0] dvd_ff, dvd_in, quo_ff, quo_in;
   logic [31:0]      rem_ff, rem_in, ad_ff, ad_in;
   logic [31:0]      ax, apd;
   logic [32:0]      trial;

   always_comb begin
      ax = x[31] ? 32'(-x) : 32'(x);
      apd = p[31] ? 32'(-p) : 32'(p);
      trial = {rem_ff, dvd_ff[DIV_W-1]};
      run_in = run_ff;
      fin_in = 1'b0;
      neg_in = neg_ff;
      cnt_in = cnt_ff;
      dvd_in = dvd_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      ad_in  = ad_ff;
      if (start) begin
         ad_in  = apd;
         dvd_in = {ax, FRAC_BITS'(0)} + DIV_W'(apd >> 1);
         rem_in = '0;
         quo_in = '0;
         cnt_in = '0;
         neg_in = x[31] ^ p[31];
         run_in = 1'b1;
      end else if (run_ff) begin
         dvd_in = {dvd_ff[DIV_W-2:0], 1'b0};
         if (trial >= {1'b0, ad_ff}) begin
            rem_in = 32'(trial - {1'b0, ad_ff});
            quo_in = {quo_ff[DIV_W-2:0], 1'b1};
         end else begin
            rem_in = trial[31:0];
            quo_in = {quo_ff[DIV_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + CW'(1);
         if (32'(cnt_ff) == DIV_W - 1) begin
            run_in = 1'b0;
            fin_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         fin_ff <= 1'b0;
      end else begin
         run_ff <= run_in;
         fin_ff <= fin_in;
      end
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
      dvd_ff <= dvd_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      ad_ff  <= ad_in;
   end

   always_comb begin
      if (!neg_ff) begin
         q = (quo_ff > DIV_W'(32'h7fffffff)) ? 32'sh7fffffff : 32'(quo_ff);
      end else begin
         q = (quo_ff > DIV_W'(33'h080000000)) ? 32'sh80000000 : 32'(-quo_ff);
      end
   end

   assign done = fin_ff;

endmodule

// ----- hdl/gji_shr.sv -----
module gji_shr (
   input  logic               clock,
   input  logic signed [31:0] f,
   input  logic signed [31:0] x,
   input  logic signed [31:0] y,
   output logic signed [31:0] q
);
   import gji_pkg::*;

   logic signed [63:0] prod_ff;
   logic signed [31:0] x_ff, q_ff, q_in;
   logic signed [63:0] rnd, m;
   logic signed [64:0] diff;

   always_comb begin
      rnd  = prod_ff + (64'sd1 <<< (FRAC_BITS - 1)) - 64'(prod_ff[63]);
      m    = rnd >>> FRAC_BITS;
      diff = 65'(x_ff) - 65'(m);
      if (diff > 65'sh07fffffff) begin
         q_in = 32'sh7fffffff;
      end else if (diff < -65'sh080000000) begin
         q_in = 32'sh80000000;
      end else begin
         q_in = 32'(diff);
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= 64'(f) * 64'(y);
      x_ff    <= x;
      q_ff    <= q_in;
   end

   assign q = q_ff;

endmodule

// ----- hdl/gauss_jordan_matrix_inverse_top.sv -----
// sequence: n*n load items, then the identity matrix is written; per column a pivot search,
// a row swap when the pivot lies below the diagonal, scaling of the pivot row through the shared
// bit-serial divider and a shear of every other row; then the n*n output entries
// throughput: one matrix at a time, busy stays high from the last item until output ends
// reset: synchronous, matrix_size returns to 4 and the load count to zero
// results come one per cycle on rsp_strobe; the receiver cannot stall
module gauss_jordan_matrix_inverse_top (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  gji_pkg::gji_req_type req_item,
   input  logic                 csr_we,
   input  logic [3:0]           csr_wdata,
   output logic                 rsp_strobe,
   output gji_pkg::gji_rsp_type rsp_item
);
   import gji_pkg::*;

   logic signed [31:0] w_mem [CELLS];
   logic signed [31:0] i_mem [CELLS];

   gji_state_type      st_ff, st_in;
   logic [3:0]         size_ff;
   logic [N_W-1:0]     r_ff, r_in, ri_ff, ri_in, c_ff, c_in, n;
   logic [CNT_W-1:0]   k_ff, k_in, load_ff, load_in, total;
   logic [2*N_W-1:0]   nn;
   logic signed [31:0] w_rd_ff, i_rd_ff, p_ff, p_in, f_ff, f_in;
   logic signed [31:0] tw_ff, tw_in, ti_ff, ti_in, yw_ff, yw_in, yi_ff, yi_in;
   logic               w_we, i_we;
   logic [CELL_W-1:0]  w_wa, i_wa, w_ra, i_ra;
   logic signed [31:0] w_wd, i_wd;
   logic               div_start, div_done;
   logic signed [31:0] div_x, div_q, sh_x, sh_y, sh_q;

   assign n     = order_n(size_ff);
   assign nn    = n * n;
   assign total = nn[CNT_W-1:0];

   gji_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .x     (div_x),
      .p     (p_ff),
      .done  (div_done),
      .q     (div_q)
   );

   gji_shr u_shr (
      .clock (clock),
      .f     (f_ff),
      .x     (sh_x),
      .y     (sh_y),
      .q     (sh_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= ST_IDLE;
         size_ff <= 4'd4;
         load_ff <= '0;
      end else begin
         st_ff   <= st_in;
         load_ff <= load_in;
         if (csr_we) begin
            size_ff <= csr_wdata;
         end
      end
      r_ff  <= r_in;
      ri_ff <= ri_in;
      c_ff  <= c_in;
      k_ff  <= k_in;
      p_ff  <= p_in;
      f_ff  <= f_in;
      tw_ff <= tw_in;
      ti_ff <= ti_in;
      yw_ff <= yw_in;
      yi_ff <= yi_in;
   end

   always_ff @(posedge clock) begin
      if (w_we) begin
         w_mem[w_wa] <= w_wd;
      end
      if (i_we) begin
         i_mem[i_wa] <= i_wd;
      end
      w_rd_ff <= w_mem[w_ra];
      i_rd_ff <= i_mem[i_ra];
   end

   always_comb begin
      st_in = st_ff;
      r_in = r_ff;
      ri_in = ri_ff;
      c_in = c_ff;
      k_in = k_ff;
      load_in = load_ff;
      p_in = p_ff;
      f_in = f_ff;
      tw_in = tw_ff;
      ti_in = ti_ff;
      yw_in = yw_ff;
      yi_in = yi_ff;
      w_we = 1'b0;
      i_we = 1'b0;
      w_wa = cell_addr(r_ff, c_ff, n);
      i_wa = cell_addr(r_ff, c_ff, n);
      w_wd = w_rd_ff;
      i_wd = i_rd_ff;
      w_ra = '0;
      i_ra = '0;
      div_start = 1'b0;
      div_x = w_rd_ff;
      sh_x = w_rd_ff;
      sh_y = yw_ff;
      busy = (st_ff != ST_IDLE);
      rsp_strobe = 1'b0;
      rsp_item.entry = i_rd_ff;
      rsp_item.last_entry = 1'b0;
      rsp_item.singular = 1'b0;
      case (st_ff)
         ST_IDLE: begin
            if (start) begin
               if (load_ff < total) begin
                  w_we = 1'b1;
                  w_wa = load_ff[CELL_W-1:0];
                  w_wd = req_item.element;
                  load_in = load_ff + CNT_W'(1);
               end
               if (req_item.last_element) begin
                  load_in = '0;
                  r_in = '0;
                  c_in = '0;
                  st_in = ST_INIT;
               end
            end
         end
         ST_INIT: begin
            i_we = 1'b1;
            i_wd = (r_ff == c_ff) ? Q_ONE : 32'sd0;
            c_in = c_ff + N_W'(1);
            if (c_ff + N_W'(1) == n) begin
               c_in = '0;
               r_in = r_ff + N_W'(1);
               if (r_ff + N_W'(1) == n) begin
                  r_in = '0;
                  st_in = ST_COL;
               end
            end
         end
         ST_COL: begin
            ri_in = r_ff;
            w_ra = cell_addr(r_ff, r_ff, n);
            st_in = ST_SRCH;
         end
         ST_SRCH: begin
            if (w_rd_ff != 32'sd0) begin
               c_in = '0;
               st_in = (ri_ff == r_ff) ? ST_PIV : ST_SWA;
            end else if (ri_ff + N_W'(1) == n) begin
               st_in = ST_SING;
            end else begin
               ri_in = ri_ff + N_W'(1);
               w_ra = cell_addr(ri_ff + N_W'(1), r_ff, n);
            end
         end
         ST_SWA: begin
            w_ra = cell_addr(r_ff, c_ff, n);
            i_ra = w_ra;
            st_in = ST_SWB;
         end
         ST_SWB: begin
            tw_in = w_rd_ff;
            ti_in = i_rd_ff;
            w_ra = cell_addr(ri_ff, c_ff, n);
            i_ra = w_ra;
            st_in = ST_SWC;
         end
         ST_SWC: begin
            w_we = 1'b1;
            i_we = 1'b1;
            st_in = ST_SWD;
         end
         ST_SWD: begin
            w_we = 1'b1;
            i_we = 1'b1;
            w_wa = cell_addr(ri_ff, c_ff, n);
            i_wa = w_wa;
            w_wd = tw_ff;
            i_wd = ti_ff;
            c_in = c_ff + N_W'(1);
            st_in = ST_SWA;
            if (c_ff + N_W'(1) == n) begin
               c_in = '0;
               st_in = ST_PIV;
            end
         end
         ST_PIV: begin
            w_ra = cell_addr(r_ff, r_ff, n);
            st_in = ST_PIV2;
         end
         ST_PIV2: begin
            p_in = w_rd_ff;
            c_in = '0;
            st_in = ST_SCA;
         end
         ST_SCA: begin
            w_ra = cell_addr(r_ff, c_ff, n);
            i_ra = w_ra;
            st_in = ST_SCB;
         end
         ST_SCB: begin
            div_start = 1'b1;
            ti_in = i_rd_ff;
            st_in = ST_SCC;
         end
         ST_SCC: begin
            div_x = ti_ff;
            if (div_done) begin
               w_we = 1'b1;
               w_wd = div_q;
               div_start = 1'b1;
               st_in = ST_SCD;
            end
         end
         ST_SCD: begin
            if (div_done) begin
               i_we = 1'b1;
               i_wd = div_q;
               c_in = c_ff + N_W'(1);
               st_in = ST_SCA;
               if (c_ff + N_W'(1) == n) begin
                  ri_in = '0;
                  st_in = ST_SHF;
               end
            end
         end
         ST_SHF: begin
            if (ri_ff == r_ff) begin
               if (ri_ff + N_W'(1) == n) begin
                  r_in = r_ff + N_W'(1);
                  k_in = '0;
                  st_in = (r_ff + N_W'(1) == n) ? ST_ORD : ST_COL;
               end else begin
                  ri_in = ri_ff + N_W'(1);
               end
            end else begin
               w_ra = cell_addr(ri_ff, r_ff, n);
               st_in = ST_SHG;
            end
         end
         ST_SHG: begin
            f_in = w_rd_ff;
            c_in = '0;
            st_in = ST_SHA;
         end
         ST_SHA: begin
            w_ra = cell_addr(r_ff, c_ff, n);
            i_ra = w_ra;
            st_in = ST_SHB;
         end
         ST_SHB: begin
            yw_in = w_rd_ff;
            yi_in = i_rd_ff;
            w_ra = cell_addr(ri_ff, c_ff, n);
            i_ra = w_ra;
            st_in = ST_SHC;
         end
         ST_SHC: begin
            ti_in = i_rd_ff;
            st_in = ST_SHD;
         end
         ST_SHD: begin
            sh_x = ti_ff;
            sh_y = yi_ff;
            st_in = ST_SHE;
         end
         ST_SHE: begin
            w_we = 1'b1;
            w_wa = cell_addr(ri_ff, c_ff, n);
            w_wd = sh_q;
            st_in = ST_SHW;
         end
         ST_SHW: begin
            i_we = 1'b1;
            i_wa = cell_addr(ri_ff, c_ff, n);
            i_wd = sh_q;
            c_in = c_ff + N_W'(1);
            st_in = ST_SHA;
            if (c_ff + N_W'(1) == n) begin
               if (ri_ff + N_W'(1) == n) begin
                  r_in = r_ff + N_W'(1);
                  k_in = '0;
                  st_in = (r_ff + N_W'(1) == n) ? ST_ORD : ST_COL;
               end else begin
                  ri_in = ri_ff + N_W'(1);
                  st_in = ST_SHF;
               end
            end
         end
         ST_ORD: begin
            i_ra = k_ff[CELL_W-1:0];
            st_in = ST_OUT;
         end
         ST_OUT: begin
            rsp_strobe = 1'b1;
            k_in = k_ff + CNT_W'(1);
            i_ra = k_in[CELL_W-1:0];
            if (k_ff + CNT_W'(1) == total) begin
               rsp_item.last_entry = 1'b1;
               st_in = ST_IDLE;
            end
         end
         ST_SING: begin
            rsp_strobe = 1'b1;
            rsp_item.entry = 32'sd0;
            rsp_item.last_entry = 1'b1;
            rsp_item.singular = 1'b1;
            st_in = ST_IDLE;
         end
         default: begin
            st_in = ST_IDLE;
         end
      endcase
   end

endmodule
